// ----- hw/rtl/acmc_pkg.sv -----
package acmc_pkg;

    localparam int unsigned ADDR_W = 2;
    localparam int unsigned DATA_W = 32;

    localparam logic [ADDR_W-1:0] ADDR_DEBOUNCE = 2'd0;
    localparam logic [15:0]       DEBOUNCE_RESET = 16'd50;
    localparam logic [5:0]        HOURS_PER_DAY = 6'd24;
    localparam logic [6:0]        MINUTES_PER_HOUR = 7'd60;

    localparam logic [6:0] SEG_CODES [10] = '{
        7'h3F, 7'h06, 7'h5B, 7'h4F, 7'h66, 7'h6D, 7'h7D, 7'h07, 7'h7F, 7'h6F
    };

    typedef enum logic [1:0] {
        MODE_NORMAL    = 2'd0,
        MODE_SET_TIME  = 2'd1,
        MODE_SET_ALARM = 2'd2
    } t_mode;

    typedef struct packed {
        logic [31:0] now_ms;
        logic        set_time_button;
        logic        set_alarm_button;
        logic        reset_button;
        logic        exit_button;
        logic        select_button;
        logic [4:0]  rtc_hour;
        logic [5:0]  rtc_minute;
    } t_in_word;

    typedef struct packed {
        logic [1:0]  mode;
        logic [4:0]  shown_hour;
        logic [5:0]  shown_minute;
        logic [27:0] segment_codes;
        logic        editing_minutes;
        logic        alarm_match;
        logic        clock_write;
        logic [4:0]  write_hour;
        logic [5:0]  write_minute;
    } t_out_word;

    typedef struct packed {
        logic [2:0] tens;
        logic [3:0] ones;
    } t_digit_pair;

    function automatic t_digit_pair split_dec(input logic [5:0] v);
        t_digit_pair d;
        if (v >= 6'd60) begin
            d.tens = 3'd6;
            d.ones = 4'(v - 6'd60);
        end else if (v >= 6'd50) begin
            d.tens = 3'd5;
            d.ones = 4'(v - 6'd50);
        end else if (v >= 6'd40) begin
            d.tens = 3'd4;
            d.ones = 4'(v - 6'd40);
        end else if (v >= 6'd30) begin
            d.tens = 3'd3;
            d.ones = 4'(v - 6'd30);
        end else if (v >= 6'd20) begin
            d.tens = 3'd2;
            d.ones = 4'(v - 6'd20);
        end else if (v >= 6'd10) begin
            d.tens = 3'd1;
            d.ones = 4'(v - 6'd10);
        end else begin
            d.tens = 3'd0;
            d.ones = v[3:0];
        end
        return d;
    endfunction

endpackage

// ----- hw/rtl/alarm_clock_mode_controller_top.sv -----
// Path: an accepted word waits in the input register, passes the state update and is
//   written to the result register; an output stall can hold it in either register.
// Throughput: one word per cycle while the output is not stalled.
// Reset: synchronous, active low; clears mode, edit and alarm values, debounce
//   bookkeeping and both handshake stages, and loads debounce_ms with 50.
module alarm_clock_mode_controller_top
    import acmc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  t_in_word          i_in_word,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output t_out_word         o_out_word,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    logic        r_in_vld;
    t_in_word    r_in;
    logic        r_out_vld;
    t_out_word   r_out;
    logic        advance;
    logic [15:0] debounce;
    t_out_word   result;

    assign advance    = r_in_vld && (!r_out_vld || !i_out_stall);
    assign o_in_stall = r_in_vld && !advance;

    acmc_apb u_apb (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .o_debounce (debounce)
    );

    acmc_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (advance),
        .i_word     (r_in),
        .i_debounce (debounce),
        .o_word     (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (i_in_valid && !o_in_stall) begin
            r_in_vld <= 1'b1;
        end else if (advance) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in <= i_in_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (advance) begin
            r_out_vld <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= result;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_word  = r_out;

    a_write_in_normal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_word.clock_write |-> o_out_word.mode == MODE_NORMAL)
        else $error("clock write outside normal mode");

    a_match_in_normal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_word.alarm_match |-> o_out_word.mode == MODE_NORMAL)
        else $error("alarm match outside normal mode");

    a_advance_fills_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> o_out_valid)
        else $error("processed word not registered");

    a_empty_no_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_in_vld |-> !o_in_stall)
        else $error("stall with empty input stage");

endmodule

// ----- hw/rtl/acmc_apb.sv -----
module acmc_apb
    import acmc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output logic [15:0]       o_debounce
);

    logic [15:0] r_debounce;
    logic        wr_en;

    assign wr_en  = psel && penable && pwrite && (paddr == ADDR_DEBOUNCE);
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce <= DEBOUNCE_RESET;
        end else if (wr_en) begin
            r_debounce <= pwdata[15:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr == ADDR_DEBOUNCE) begin
            prdata = {16'd0, r_debounce};
        end
    end

    assign o_debounce = r_debounce;

endmodule

// ----- hw/rtl/acmc_disp.sv -----
module acmc_disp
    import acmc_pkg::*;
(
    input  logic [4:0]  i_hour,
    input  logic [5:0]  i_minute,
    output logic [27:0] o_codes
);

    t_digit_pair hd;
    t_digit_pair md;

    assign hd = split_dec({1'b0, i_hour});
    assign md = split_dec(i_minute);

    assign o_codes = {SEG_CODES[md.ones], SEG_CODES[{1'b0, md.tens}],
                      SEG_CODES[hd.ones], SEG_CODES[{1'b0, hd.tens}]};

endmodule

// ----- hw/rtl/acmc_core.sv -----
module acmc_core
    import acmc_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_en,
    input  t_in_word  i_word,
    input  logic [15:0] i_debounce,
    output t_out_word o_word
);

    t_mode       r_mode, n_mode;
    logic [4:0]  r_edit_hour, n_edit_hour;
    logic [5:0]  r_edit_minute, n_edit_minute;
    logic [4:0]  r_alarm_hour, n_alarm_hour;
    logic [5:0]  r_alarm_minute, n_alarm_minute;
    logic        r_field, n_field;
    logic        r_pending, n_pending;
    logic [31:0] r_last, n_last;
    logic        r_sel_stable, n_sel_stable;
    logic        r_sel_prev;

    logic [31:0] elapsed;
    logic        ok0, ok_fin, sel_chg, any_ev;
    logic        ev_time, ev_alarm, ev_rst, ev_exit;
    logic        pend;
    logic [4:0]  eh, ah, sh;
    logic [5:0]  em, am, sm;
    logic [5:0]  h_inc;
    logic [6:0]  m_inc;
    logic [27:0] codes;

    assign elapsed  = i_word.now_ms - r_last;
    assign ok0      = elapsed > {16'd0, i_debounce};
    assign ev_time  = i_word.set_time_button && ok0;
    assign ev_alarm = i_word.set_alarm_button && ok0 && !ev_time;
    assign ev_rst   = i_word.reset_button && ok0 && !ev_time && !ev_alarm;
    assign ev_exit  = i_word.exit_button && ok0 && !ev_time && !ev_alarm && !ev_rst;
    assign any_ev   = ev_time || ev_alarm || ev_rst || ev_exit;
    assign sel_chg  = i_word.select_button != r_sel_prev;
    assign ok_fin   = ok0 && !any_ev && !sel_chg;

    always_comb begin
        n_mode = r_mode;
        unique case (r_mode)
            MODE_NORMAL: begin
                if (ev_time) begin
                    n_mode = MODE_SET_TIME;
                end else if (ev_alarm) begin
                    n_mode = MODE_SET_ALARM;
                end
            end
            MODE_SET_TIME, MODE_SET_ALARM: begin
                if (ev_exit) begin
                    n_mode = MODE_NORMAL;
                end
            end
            default: n_mode = MODE_NORMAL;
        endcase
    end

    always_comb begin
        n_last       = (any_ev || sel_chg) ? i_word.now_ms : r_last;
        n_field      = r_field;
        n_sel_stable = r_sel_stable;
        if (ok_fin) begin
            if (i_word.select_button && !r_sel_stable) begin
                n_field = !r_field;
            end
            n_sel_stable = i_word.select_button;
        end

        pend = r_pending || ev_rst;
        eh = (r_mode == MODE_NORMAL && ev_time) ? 5'd0 : r_edit_hour;
        em = (r_mode == MODE_NORMAL && ev_time) ? 6'd0 : r_edit_minute;
        ah = (r_mode == MODE_NORMAL && ev_alarm) ? 5'd0 : r_alarm_hour;
        am = (r_mode == MODE_NORMAL && ev_alarm) ? 6'd0 : r_alarm_minute;
        n_pending = pend;

        n_edit_hour    = eh;
        n_edit_minute  = em;
        n_alarm_hour   = ah;
        n_alarm_minute = am;
        sh    = i_word.rtc_hour;
        sm    = i_word.rtc_minute;
        h_inc = '0;
        m_inc = '0;

        unique case (n_mode)
            MODE_SET_TIME: begin
                if (pend) begin
                    eh = '0;
                    em = '0;
                    n_pending = 1'b0;
                end
                sh = eh;
                sm = em;
                h_inc = {1'b0, eh} + 6'd1;
                m_inc = {1'b0, em} + 7'd1;
                n_edit_hour   = eh;
                n_edit_minute = em;
                if (i_word.set_time_button) begin
                    if (!n_field) begin
                        n_edit_hour = (h_inc >= HOURS_PER_DAY) ? 5'd0 : h_inc[4:0];
                    end else begin
                        n_edit_minute = (m_inc >= MINUTES_PER_HOUR) ? 6'd0 : m_inc[5:0];
                    end
                end
            end
            MODE_SET_ALARM: begin
                if (pend) begin
                    ah = '0;
                    am = '0;
                    n_pending = 1'b0;
                end
                sh = ah;
                sm = am;
                h_inc = {1'b0, ah} + 6'd1;
                m_inc = {1'b0, am} + 7'd1;
                n_alarm_hour   = ah;
                n_alarm_minute = am;
                if (i_word.set_alarm_button) begin
                    if (!n_field) begin
                        n_alarm_hour = (h_inc >= HOURS_PER_DAY) ? 5'd0 : h_inc[4:0];
                    end else begin
                        n_alarm_minute = (m_inc >= MINUTES_PER_HOUR) ? 6'd0 : m_inc[5:0];
                    end
                end
            end
            default: begin
                sh = i_word.rtc_hour;
                sm = i_word.rtc_minute;
            end
        endcase
    end

    acmc_disp u_disp (
        .i_hour   (sh),
        .i_minute (sm),
        .o_codes  (codes)
    );

    always_comb begin
        o_word                 = '0;
        o_word.mode            = n_mode;
        o_word.shown_hour      = sh;
        o_word.shown_minute    = sm;
        o_word.segment_codes   = codes;
        o_word.editing_minutes = n_field;
        o_word.alarm_match     = (n_mode == MODE_NORMAL)
                                 && (i_word.rtc_hour == r_alarm_hour)
                                 && (i_word.rtc_minute == r_alarm_minute);
        o_word.clock_write     = ev_exit && (r_mode == MODE_SET_TIME);
        if (o_word.clock_write) begin
            o_word.write_hour   = r_edit_hour;
            o_word.write_minute = r_edit_minute;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode         <= MODE_NORMAL;
            r_edit_hour    <= '0;
            r_edit_minute  <= '0;
            r_alarm_hour   <= '0;
            r_alarm_minute <= '0;
            r_field        <= 1'b0;
            r_pending      <= 1'b0;
            r_last         <= '0;
            r_sel_stable   <= 1'b0;
            r_sel_prev     <= 1'b0;
        end else if (i_en) begin
            r_mode         <= n_mode;
            r_edit_hour    <= n_edit_hour;
            r_edit_minute  <= n_edit_minute;
            r_alarm_hour   <= n_alarm_hour;
            r_alarm_minute <= n_alarm_minute;
            r_field        <= n_field;
            r_pending      <= n_pending;
            r_last         <= n_last;
            r_sel_stable   <= n_sel_stable;
            r_sel_prev     <= i_word.select_button;
        end
    end

endmodule

// ----- dv/testbench.sv -----
`timescale 1ns / 100ps

module testbench;
    import acmc_pkg::*;

    localparam logic [4:0] BTN_NONE   = 5'b00000;
    localparam logic [4:0] BTN_TIME   = 5'b10000;
    localparam logic [4:0] BTN_ALARM  = 5'b01000;
    localparam logic [4:0] BTN_RESET  = 5'b00100;
    localparam logic [4:0] BTN_EXIT   = 5'b00010;
    localparam logic [4:0] BTN_SELECT = 5'b00001;

    logic              i_clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              in_valid = 1'b0;
    t_in_word          in_word = '0;
    logic              out_stall = 1'b0;
    logic              o_in_stall;
    logic              o_out_valid;
    t_out_word         o_out_word;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [DATA_W-1:0] pwdata = '0;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    t_in_word  loop_inputs[$];
    t_out_word predicted_outputs[$];
    int        passes_queued = 0;
    int        passes_sent = 0;
    int        passes_seen = 0;
    int        fault_count = 0;
    int        hold_left = 0;
    bit        held_once = 1'b0;
    logic [31:0] t_cursor = '0;

    logic [15:0] debounce_cfg = DEBOUNCE_RESET;
    t_mode       mode_q = MODE_NORMAL;
    logic [4:0]  edit_h = '0;
    logic [5:0]  edit_m = '0;
    logic [4:0]  alarm_h = '0;
    logic [5:0]  alarm_m = '0;
    logic        field_min = 1'b0;
    logic        rst_pend = 1'b0;
    logic [31:0] last_evt = '0;
    logic        sel_stable = 1'b0;
    logic        sel_prev = 1'b0;

    alarm_clock_mode_controller_top DUT (
        .i_clk      (i_clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_stall (o_in_stall),
        .i_in_word  (in_word),
        .o_out_valid(o_out_valid),
        .i_out_stall(out_stall),
        .o_out_word (o_out_word),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    always #4 i_clk = ~i_clk;

    function automatic bit debounce_ok(logic [31:0] now);
        logic [31:0] elapsed;
        elapsed = now - last_evt;
        return elapsed > {16'd0, debounce_cfg};
    endfunction

    function automatic logic [6:0] seg_of(int unsigned d);
        case (d)
            0: return 7'h3F;
            1: return 7'h06;
            2: return 7'h5B;
            3: return 7'h4F;
            4: return 7'h66;
            5: return 7'h6D;
            6: return 7'h7D;
            7: return 7'h07;
            8: return 7'h7F;
            9: return 7'h6F;
            default: return 7'h00;
        endcase
    endfunction

    function automatic logic [4:0] next_hour(logic [4:0] h);
        logic [5:0] n;
        n = h + 6'd1;
        return (n >= HOURS_PER_DAY) ? 5'd0 : n[4:0];
    endfunction

    function automatic logic [5:0] next_minute(logic [5:0] m);
        logic [6:0] n;
        n = m + 7'd1;
        return (n >= MINUTES_PER_HOUR) ? 6'd0 : n[5:0];
    endfunction

    function automatic t_out_word run_control_pass(t_in_word w);
        t_out_word r;
        int unsigned h;
        int unsigned m;
        r = '0;
        if (w.set_time_button && debounce_ok(w.now_ms)) begin
            last_evt = w.now_ms;
            if (mode_q == MODE_NORMAL) begin
                mode_q = MODE_SET_TIME;
                edit_h = '0;
                edit_m = '0;
            end
        end
        if (w.set_alarm_button && debounce_ok(w.now_ms)) begin
            last_evt = w.now_ms;
            if (mode_q == MODE_NORMAL) begin
                mode_q = MODE_SET_ALARM;
                alarm_h = '0;
                alarm_m = '0;
            end
        end
        if (w.reset_button && debounce_ok(w.now_ms)) begin
            last_evt = w.now_ms;
            rst_pend = 1'b1;
        end
        if (w.exit_button && debounce_ok(w.now_ms)) begin
            last_evt = w.now_ms;
            if (mode_q == MODE_SET_TIME) begin
                r.clock_write = 1'b1;
                r.write_hour = edit_h;
                r.write_minute = edit_m;
                mode_q = MODE_NORMAL;
            end else if (mode_q == MODE_SET_ALARM) begin
                mode_q = MODE_NORMAL;
            end
        end
        if (w.select_button != sel_prev)
            last_evt = w.now_ms;
        if (debounce_ok(w.now_ms)) begin
            if (w.select_button && !sel_stable)
                field_min = ~field_min;
            sel_stable = w.select_button;
        end
        sel_prev = w.select_button;

        if (mode_q == MODE_SET_TIME) begin
            if (rst_pend) begin
                edit_h = '0;
                edit_m = '0;
                rst_pend = 1'b0;
            end
            r.shown_hour = edit_h;
            r.shown_minute = edit_m;
            if (w.set_time_button) begin
                if (field_min)
                    edit_m = next_minute(edit_m);
                else
                    edit_h = next_hour(edit_h);
            end
        end else if (mode_q == MODE_SET_ALARM) begin
            if (rst_pend) begin
                alarm_h = '0;
                alarm_m = '0;
                rst_pend = 1'b0;
            end
            r.shown_hour = alarm_h;
            r.shown_minute = alarm_m;
            if (w.set_alarm_button) begin
                if (field_min)
                    alarm_m = next_minute(alarm_m);
                else
                    alarm_h = next_hour(alarm_h);
            end
        end else begin
            r.shown_hour = w.rtc_hour;
            r.shown_minute = w.rtc_minute;
            r.alarm_match = (w.rtc_hour == alarm_h) && (w.rtc_minute == alarm_m);
        end
        h = 32'(r.shown_hour);
        m = 32'(r.shown_minute);
        r.segment_codes = {seg_of(m % 10), seg_of((m / 10) % 10),
                           seg_of(h % 10), seg_of((h / 10) % 10)};
        r.mode = mode_q;
        r.editing_minutes = field_min;
        return r;
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $display("%0t %s: expected %0h, got %0h", $time, name, want, got);
            fault_count++;
        end
    endfunction

    always @(posedge i_clk) begin : drive
        bit rest;
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && !o_in_stall) begin
                predicted_outputs.push_back(run_control_pass(in_word));
                passes_sent++;
            end
            if (!in_valid || !o_in_stall) begin
                rest = ($urandom_range(0, 99) < 35) && !(passes_sent >= 200 && passes_sent < 350);
                if (loop_inputs.size() != 0 && !rest) begin
                    in_valid <= 1'b1;
                    in_word <= loop_inputs.pop_front();
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin : watch
        t_out_word want;
        if (rst_n) begin
            if (o_out_valid && !out_stall) begin
                if (predicted_outputs.size() == 0) begin
                    $display("%0t unexpected word: expected none, got %h", $time, o_out_word);
                    fault_count++;
                end else begin
                    want = predicted_outputs.pop_front();
                    check_field("mode", 32'(want.mode), 32'(o_out_word.mode));
                    check_field("shown_hour", 32'(want.shown_hour),
                                32'(o_out_word.shown_hour));
                    check_field("shown_minute", 32'(want.shown_minute),
                                32'(o_out_word.shown_minute));
                    check_field("segment_codes", 32'(want.segment_codes),
                                32'(o_out_word.segment_codes));
                    check_field("editing_minutes", 32'(want.editing_minutes),
                                32'(o_out_word.editing_minutes));
                    check_field("alarm_match", 32'(want.alarm_match),
                                32'(o_out_word.alarm_match));
                    check_field("clock_write", 32'(want.clock_write),
                                32'(o_out_word.clock_write));
                    check_field("write_hour", 32'(want.write_hour),
                                32'(o_out_word.write_hour));
                    check_field("write_minute", 32'(want.write_minute),
                                32'(o_out_word.write_minute));
                end
                passes_seen++;
            end
            if (hold_left != 0) begin
                hold_left--;
                out_stall <= 1'b1;
            end else if (passes_seen == 150 && !held_once) begin
                held_once = 1'b1;
                hold_left = 80;
                out_stall <= 1'b1;
            end else begin
                out_stall <= ($urandom_range(0, 99) < 35)
                             && !(passes_seen >= 200 && passes_seen < 350);
            end
        end
    end

    task automatic push_pass(logic [4:0] btn, logic [31:0] now, logic [4:0] h, logic [5:0] m);
        t_in_word w;
        w.now_ms = now;
        {w.set_time_button, w.set_alarm_button, w.reset_button,
         w.exit_button, w.select_button} = btn;
        w.rtc_hour = h;
        w.rtc_minute = m;
        loop_inputs.push_back(w);
        passes_queued++;
    endtask

    function automatic logic [31:0] gap_ms();
        case ($urandom_range(0, 4))
            0: return $urandom_range(0, debounce_cfg);
            1: return 32'(debounce_cfg);
            2: return debounce_cfg + 32'd1;
            default: return debounce_cfg + 32'd1 + $urandom_range(0, debounce_cfg + 5);
        endcase
    endfunction

    task automatic step(logic [4:0] btn);
        logic [4:0] h;
        logic [5:0] m;
        case ($urandom_range(0, 3))
            0: begin h = 5'($urandom_range(0, 31)); m = 6'($urandom_range(0, 63)); end
            1: begin h = 5'($urandom_range(0, 23)); m = 6'($urandom_range(0, 59)); end
            default: begin h = 5'($urandom_range(0, 2)); m = 6'($urandom_range(0, 3)); end
        endcase
        t_cursor = t_cursor + gap_ms();
        push_pass(btn, t_cursor, h, m);
    endtask

    task automatic run_session();
        logic [4:0] key;
        key = $urandom_range(0, 1) ? BTN_TIME : BTN_ALARM;
        repeat ($urandom_range(1, 6)) step(key);
        step(BTN_NONE);
        if ($urandom_range(0, 1)) begin
            repeat ($urandom_range(1, 3)) step(BTN_SELECT);
            step(BTN_NONE);
        end
        repeat ($urandom_range(1, 8)) step(key);
        step(BTN_NONE);
        if ($urandom_range(0, 3) == 0) begin
            step(BTN_RESET);
            step(BTN_NONE);
        end
        if ($urandom_range(0, 9) == 0)
            repeat ($urandom_range(20, 65)) step(key);
        step(BTN_EXIT);
        step(BTN_NONE);
        repeat ($urandom_range(0, 4)) step(BTN_NONE);
    endtask

    task automatic run_random(int count);
        int goal;
        goal = passes_queued + count;
        while (passes_queued < goal) begin
            case ($urandom_range(0, 9))
                6, 7: begin
                    repeat ($urandom_range(1, 6)) begin
                        if ($urandom_range(0, 7) == 0)
                            t_cursor = $urandom();
                        step(5'($urandom()));
                    end
                end
                8: begin
                    t_cursor = 32'hFFFF_FFFF - $urandom_range(0, 2 * debounce_cfg + 2);
                    run_session();
                end
                default: run_session();
            endcase
        end
    endtask

    task automatic wait_drained();
        while (loop_inputs.size() != 0 || in_valid || predicted_outputs.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic apb_cycle(logic wr, logic [ADDR_W-1:0] addr, logic [DATA_W-1:0] data,
                             output logic [DATA_W-1:0] rdata);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= wr;
        paddr <= addr;
        pwdata <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rdata = prdata;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic set_debounce(logic [15:0] value);
        logic [DATA_W-1:0] rdata;
        wait_drained();
        apb_cycle(1'b1, ADDR_DEBOUNCE, {16'd0, value}, rdata);
        debounce_cfg = value;
        apb_cycle(1'b0, ADDR_DEBOUNCE, '0, rdata);
        check_field("debounce_ms readback", 32'(value), 32'(rdata[15:0]));
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        rst_n <= 1'b1;
        @(posedge i_clk);

        set_debounce(16'd50);
        push_pass(BTN_NONE, 32'd0, 5'd0, 6'd0);
        push_pass(BTN_NONE, 32'd10, 5'd23, 6'd59);
        push_pass(BTN_NONE, 32'd20, 5'd31, 6'd63);
        push_pass(BTN_EXIT, 32'd100, 5'd12, 6'd34);
        push_pass(BTN_RESET, 32'd200, 5'd5, 6'd7);
        push_pass(BTN_TIME, 32'd300, 5'd9, 6'd9);
        push_pass(BTN_TIME, 32'd320, 5'd9, 6'd9);
        push_pass(BTN_SELECT, 32'd400, 5'd1, 6'd1);
        push_pass(BTN_SELECT, 32'd451, 5'd1, 6'd1);
        push_pass(BTN_NONE, 32'd460, 5'd1, 6'd1);
        push_pass(BTN_ALARM, 32'd600, 5'd2, 6'd2);
        push_pass(BTN_TIME | BTN_ALARM | BTN_RESET, 32'd700, 5'd2, 6'd2);
        push_pass(BTN_NONE, 32'd720, 5'd2, 6'd2);
        push_pass(BTN_EXIT, 32'd800, 5'd2, 6'd2);
        push_pass(BTN_ALARM, 32'd900, 5'd0, 6'd0);
        push_pass(BTN_ALARM, 32'd910, 5'd0, 6'd0);
        push_pass(BTN_NONE, 32'd920, 5'd0, 6'd0);
        push_pass(BTN_EXIT, 32'd1000, 5'd0, 6'd1);
        push_pass(BTN_NONE, 32'd1010, 5'd0, 6'd2);
        push_pass(BTN_NONE, 32'd1020, 5'd0, 6'd0);
        push_pass(BTN_TIME, 32'hFFFF_FFF0, 5'd20, 6'd40);
        push_pass(BTN_EXIT, 32'h0000_0030, 5'd20, 6'd40);
        push_pass(BTN_TIME, 32'h0000_0062, 5'd20, 6'd40);
        push_pass(BTN_TIME, 32'h0000_0063, 5'd20, 6'd40);
        push_pass(BTN_EXIT, 32'h0000_00A0, 5'd20, 6'd40);
        t_cursor = 32'h0000_00A0;
        run_random(300);

        set_debounce(16'd0);
        run_random(120);
        set_debounce(16'hFFFF);
        run_random(120);
        set_debounce(16'($urandom_range(1, 300)));
        run_random(160);
        set_debounce(16'd1);
        run_random(100);

        wait_drained();
        repeat (10) @(posedge i_clk);
        if (fault_count == 0)
            $display("alarm_clock_mode_controller_top: match");
        else
            $display("alarm_clock_mode_controller_top: mismatch");
        $finish;
    end

    initial begin
        #2000000;
        $display("alarm_clock_mode_controller_top: mismatch");
        $finish;
    end

endmodule
